/* rtl/gdas_pkg.sv */
// ----------------------------------------------------------------------------
// gdas_pkg: shared types and constants for the date add/subtract block
// Field widths, status codes, register indexes, sequencer states and the
// month length table.
// ----------------------------------------------------------------------------
package gdas_pkg;

   localparam int DAY_W      = 5;
   localparam int MONTH_W    = 4;
   localparam int YEAR_W     = 14;
   localparam int COUNT_BITS = 16;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;

   // y / 100 as (y * 5243) >> 19, exact for every 14-bit year
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;
   localparam int          QUOT_W      = 8;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_DATE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_YEAR_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_YEAR_MAX = 2'd1;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_SUB = 1'b1;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [DAY_W-1:0]   DEC_DAYS  = 5'd31;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEAP_Q,
      ST_LEAP_R,
      ST_CHECK,
      ST_STEP,
      ST_FINISH
   } gdas_state_type;

   typedef struct packed {
      logic [DAY_W-1:0]      day;
      logic [MONTH_W-1:0]    month;
      logic [YEAR_W-1:0]     year;
      logic [COUNT_BITS-1:0] count;
      logic                  done;
      logic                  year_change;
      logic                  overflow;
   } gdas_step_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

/* rtl/gdas_step.sv */
// ----------------------------------------------------------------------------
// gdas_step: one month step of the date walk
// Shared add/compare unit: moves the working date forward or backward by
// at most one month and reports wrap, overflow and completion.
// ----------------------------------------------------------------------------
module gdas_step
   import gdas_pkg::*;
(
   input  logic                  op,
   input  logic [DAY_W-1:0]      day,
   input  logic [MONTH_W-1:0]    month,
   input  logic [YEAR_W-1:0]     year,
   input  logic [COUNT_BITS-1:0] count,
   input  logic                  leap,
   input  logic [YEAR_W-1:0]     year_min,
   input  logic [YEAR_W-1:0]     year_max,
   output gdas_step_type         step
);

   logic [DAY_W-1:0]      cur_len;
   logic [DAY_W-1:0]      prev_len;
   logic [COUNT_BITS:0]   reach;
   logic [DAY_W-1:0]      gap;
   logic [MONTH_W-1:0]    prev_month;

   assign cur_len    = month_len(month, leap);
   assign prev_month = month - MONTH_W'(1);
   assign prev_len   = month_len(prev_month, leap);
   assign reach      = {1'b0, count} + (COUNT_BITS+1)'(day);
   assign gap        = cur_len - day;

   always_comb begin
      step             = '0;
      step.day         = day;
      step.month       = month;
      step.year        = year;
      step.count       = count;
      if (op == OP_ADD) begin
         if (reach <= (COUNT_BITS+1)'(cur_len)) begin
            // lands inside this month
            step.day   = day + count[DAY_W-1:0];
            step.count = '0;
         end else begin
            step.count = count - COUNT_BITS'(gap);
            step.day   = '0;
            if (month == MONTH_DEC) begin
               step.month       = MONTH_JAN;
               step.year        = year + YEAR_W'(1);
               step.year_change = 1'b1;
               step.overflow    = (year >= year_max);
            end else begin
               step.month = month + MONTH_W'(1);
            end
         end
      end else begin
         if (count < COUNT_BITS'(day)) begin
            step.day   = day - count[DAY_W-1:0];
            step.count = '0;
         end else begin
            step.count = count - COUNT_BITS'(day);
            if (month == MONTH_JAN) begin
               step.month       = MONTH_DEC;
               step.year        = year - YEAR_W'(1);
               step.day         = DEC_DAYS;
               step.year_change = 1'b1;
               step.overflow    = (year <= year_min);
            end else begin
               step.month = prev_month;
               step.day   = prev_len;
            end
         end
      end
      step.done = (step.count == '0);
   end

endmodule

/* rtl/gregorian_date_add_sub_days.sv */
// ----------------------------------------------------------------------------
// gregorian_date_add_sub_days: add or subtract a day count to a date
// Validates a Gregorian date against month lengths and the configured year
// window, then walks month by month to the resulting date.
// ----------------------------------------------------------------------------
//
//  channel  direction  tdata / data                          tuser
//  req      in         day, month, year, day_count           operation
//  rsp      out        result_day, result_month, result_year status
//  csr      in         csr_index, csr_data (write only)      -
//
//  A transaction runs the leap computation and the check, then walks the
//  months; every year boundary crossed recomputes leap through the reciprocal
//  multiplier before the walk resumes. The result is then loaded and the
//  sequencer returns to idle; a new request is taken only in idle.
//  The month step unit advances one month per cycle between year boundaries.
//  Reset clears the sequencer, the result valid flag and loads the year
//  window defaults 1902..2037. A stalled result sits in the output register
//  while the next request is accepted.
//
module gregorian_date_add_sub_days
   import gdas_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // day[4:0], month[8:5], year[22:9], day_count[38:23], zero[39]
   input  logic [39:0]          req_tdata,
   // operation[0]
   input  logic                 req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // result_day[4:0], result_month[8:5], result_year[22:9], zero[23]
   output logic [23:0]          rsp_tdata,
   // status[1:0]
   output logic [STATUS_W-1:0]  rsp_tuser,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [YEAR_W-1:0]    csr_data
);

   gdas_state_type        state_ff, state_in;
   logic [YEAR_W-1:0]     year_min_ff, year_min_in;
   logic [YEAR_W-1:0]     year_max_ff, year_max_in;
   logic                  op_ff, op_in;
   logic [DAY_W-1:0]      day0_ff, day0_in;
   logic [MONTH_W-1:0]    month0_ff, month0_in;
   logic [YEAR_W-1:0]     year0_ff, year0_in;
   logic [DAY_W-1:0]      day_ff, day_in;
   logic [MONTH_W-1:0]    month_ff, month_in;
   logic [YEAR_W-1:0]     year_ff, year_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [QUOT_W-1:0]     quot_ff, quot_in;
   logic                  leap_ff, leap_in;
   logic                  checked_ff, checked_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [23:0]           rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]   rsp_user_ff, rsp_user_in;

   logic [YEAR_W+12:0]    prod;
   logic [YEAR_W:0]       hundreds;
   logic [YEAR_W-1:0]     rem100;
   logic                  leap_calc;
   logic                  date_ok;
   gdas_step_type         step;

   gdas_step u_step (
      .op       (op_ff),
      .day      (day_ff),
      .month    (month_ff),
      .year     (year_ff),
      .count    (count_ff),
      .leap     (leap_ff),
      .year_min (year_min_ff),
      .year_max (year_max_ff),
      .step     (step)
   );

   // leap rule: y % 4 from the low bits, y % 100 and y % 400 from the quotient
   assign prod      = (YEAR_W+13)'(year_ff) * (YEAR_W+13)'(RECIP_100);
   assign hundreds  = {{(YEAR_W+1-QUOT_W){1'b0}}, quot_ff} * (YEAR_W+1)'(100);
   assign rem100    = year_ff - hundreds[YEAR_W-1:0];
   assign leap_calc = (year_ff[1:0] == 2'b00) &&
                      ((rem100 != '0) || (quot_ff[1:0] == 2'b00));

   assign date_ok = (year_ff >= year_min_ff) && (year_ff <= year_max_ff) &&
                    (month_ff >= MONTH_JAN) && (month_ff <= MONTH_DEC) &&
                    (day_ff != '0) && (day_ff <= month_len(month_ff, leap_ff));

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         year_min_ff  <= YEAR_W'(1902);
         year_max_ff  <= YEAR_W'(2037);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         year_min_ff  <= year_min_in;
         year_max_ff  <= year_max_in;
      end
      op_ff       <= op_in;
      day0_ff     <= day0_in;
      month0_ff   <= month0_in;
      year0_ff    <= year0_in;
      day_ff      <= day_in;
      month_ff    <= month_in;
      year_ff     <= year_in;
      count_ff    <= count_in;
      quot_ff     <= quot_in;
      leap_ff     <= leap_in;
      checked_ff  <= checked_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_comb begin
      state_in     = state_ff;
      year_min_in  = year_min_ff;
      year_max_in  = year_max_ff;
      op_in        = op_ff;
      day0_in      = day0_ff;
      month0_in    = month0_ff;
      year0_in     = year0_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      count_in     = count_ff;
      quot_in      = quot_ff;
      leap_in      = leap_ff;
      checked_in   = checked_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      // register writes; indexes beyond the list are dropped
      if (csr_valid) begin
         if (csr_index == CSR_YEAR_MIN) begin
            year_min_in = csr_data;
         end else if (csr_index == CSR_YEAR_MAX) begin
            year_max_in = csr_data;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in      = req_tuser;
               day0_in    = req_tdata[4:0];
               month0_in  = req_tdata[8:5];
               year0_in   = req_tdata[22:9];
               day_in     = req_tdata[4:0];
               month_in   = req_tdata[8:5];
               year_in    = req_tdata[22:9];
               count_in   = req_tdata[23 +: COUNT_BITS];
               checked_in = 1'b0;
               status_in  = STATUS_OK;
               state_in   = ST_LEAP_Q;
            end
         end
         ST_LEAP_Q: begin
            // hold the quotient y / 100 for the remainder cycle
            quot_in  = prod[RECIP_SHIFT +: QUOT_W];
            state_in = ST_LEAP_R;
         end
         ST_LEAP_R: begin
            leap_in  = leap_calc;
            state_in = checked_ff ? ST_STEP : ST_CHECK;
         end
         ST_CHECK: begin
            checked_in = 1'b1;
            if (!date_ok) begin
               status_in = STATUS_BAD_DATE;
               state_in  = ST_FINISH;
            end else if (count_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (step.overflow) begin
               // year left the window: drop the walk, return the input date
               status_in = STATUS_RANGE;
               state_in  = ST_FINISH;
            end else begin
               day_in   = step.day;
               month_in = step.month;
               year_in  = step.year;
               count_in = step.count;
               if (step.done) begin
                  state_in = ST_FINISH;
               end else if (step.year_change) begin
                  state_in = ST_LEAP_Q;
               end
            end
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               if (status_ff == STATUS_OK) begin
                  rsp_data_in = {1'b0, year_ff, month_ff, day_ff};
               end else begin
                  rsp_data_in = {1'b0, year0_ff, month0_ff, day0_ff};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // an accepted request always starts with the leap computation
   a_start_leap: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_LEAP_Q))
      else $error("request did not start the leap computation");

   // the walk never runs outside the configured year window
   a_step_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |->
         ((year_ff >= year_min_ff) && (year_ff <= year_max_ff)))
      else $error("month walk outside the year window");

   // the walk only visits real months
   a_step_month: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> ((month_ff >= MONTH_JAN) && (month_ff <= MONTH_DEC)))
      else $error("month walk on an invalid month");

   // a successful result is a real date
   a_ok_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_user_ff == STATUS_OK)) |->
         ((rsp_data_ff[4:0] != '0) && (rsp_data_ff[8:5] >= MONTH_JAN) &&
          (rsp_data_ff[8:5] <= MONTH_DEC)))
      else $error("ok status with an impossible date");

   // a finished transaction is loaded into the output register
   a_finish_load: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready)) |=>
         (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished transaction not presented");

endmodule

/* tb/gdas_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gdas_checker: result predictor and scoreboard for the date add/sub block
// Watches the request, result and register write channels. Predicts the
// result date for every accepted request and compares each accepted result.
// ----------------------------------------------------------------------------
module gdas_checker
   import gdas_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [39:0]          req_tdata,
   input  logic                 req_tuser,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [23:0]          rsp_tdata,
   input  logic [STATUS_W-1:0]  rsp_tuser,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [YEAR_W-1:0]    csr_data,
   output int                   error_count,
   output int                   outstanding
);

   typedef struct {
      logic [DAY_W-1:0]    day;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
      logic [STATUS_W-1:0] status;
   } date_result_type;

   date_result_type expected_dates[$];
   int              window_lo;
   int              window_hi;

   function automatic int days_in(input int m, input int y);
      int  len;
      bit  leap;
      leap = (y % 4 == 0) && ((y % 400 == 0) || (y % 100 != 0));
      case (m)
         1, 3, 5, 7, 8, 10, 12: len = 31;
         4, 6, 9, 11:           len = 30;
         2:                     len = leap ? 29 : 28;
         default:               len = 0;
      endcase
      return len;
   endfunction

   function automatic date_result_type shift_date(input logic                  op,
                                                  input logic [DAY_W-1:0]      d0,
                                                  input logic [MONTH_W-1:0]    m0,
                                                  input logic [YEAR_W-1:0]     y0,
                                                  input logic [COUNT_BITS-1:0] cnt,
                                                  input int                    lo,
                                                  input int                    hi);
      date_result_type r;
      int              d;
      int              m;
      int              y;
      int              len;
      int              left;
      d = int'(d0);
      m = int'(m0);
      y = int'(y0);
      left = int'(cnt);
      r.status = STATUS_OK;
      if (y < lo || y > hi || m < 1 || m > 12 || d < 1 || d > days_in(m, y)) begin
         r.status = STATUS_BAD_DATE;
      end else if (op == OP_ADD) begin
         while (left > 0 && r.status == STATUS_OK) begin
            len = days_in(m, y);
            if (d + left <= len) begin
               d = d + left;
               left = 0;
            end else begin
               // jump to day zero of the next month
               left = left - (len - d);
               d = 0;
               m = m + 1;
               if (m > 12) begin
                  m = 1;
                  y = y + 1;
                  if (y > hi) r.status = STATUS_RANGE;
               end
            end
         end
      end else begin
         while (left > 0 && r.status == STATUS_OK) begin
            if (left < d) begin
               d = d - left;
               left = 0;
            end else begin
               // fall back to the last day of the previous month
               left = left - d;
               m = m - 1;
               if (m < 1) begin
                  m = 12;
                  y = y - 1;
               end
               if (y < lo) r.status = STATUS_RANGE;
               else d = days_in(m, y);
            end
         end
      end
      if (r.status != STATUS_OK) begin
         d = int'(d0);
         m = int'(m0);
         y = int'(y0);
      end
      r.day   = d[DAY_W-1:0];
      r.month = m[MONTH_W-1:0];
      r.year  = y[YEAR_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      date_result_type want;
      if (reset) begin
         window_lo = 1902;
         window_hi = 2037;
         error_count = 0;
         expected_dates.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            expected_dates.push_back(shift_date(req_tuser, req_tdata[4:0], req_tdata[8:5],
                                                req_tdata[22:9], req_tdata[38:23],
                                                window_lo, window_hi));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_dates.size() == 0) begin
               $error("unexpected result transaction: tdata %h tuser %0d",
                      rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               want = expected_dates.pop_front();
               if (rsp_tdata[4:0] !== want.day) begin
                  $error("result_day: expected %0d, actual %0d", want.day, rsp_tdata[4:0]);
                  error_count++;
               end
               if (rsp_tdata[8:5] !== want.month) begin
                  $error("result_month: expected %0d, actual %0d", want.month,
                         rsp_tdata[8:5]);
                  error_count++;
               end
               if (rsp_tdata[22:9] !== want.year) begin
                  $error("result_year: expected %0d, actual %0d", want.year,
                         rsp_tdata[22:9]);
                  error_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_YEAR_MIN) window_lo = int'(csr_data);
            else if (csr_index == CSR_YEAR_MAX) window_hi = int'(csr_data);
         end
      end
      outstanding = expected_dates.size();
   end

endmodule

/* tb/gregorian_date_add_sub_days_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_date_add_sub_days_tb: stimulus and verdict for the date block
// Drives directed edge dates, then random dates over several year windows
// and idle patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module gregorian_date_add_sub_days_tb;
   import gdas_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;   // idle cycles before giving up
   localparam int RX_HOLD_CYCLES = 3000;    // long result stall for back pressure
   localparam int DRAIN_CYCLES   = 3000;    // covers one full 16-bit walk
   localparam int ITEMS_PER_SET  = 32;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [39:0]          req_tdata;        // day, month, year, day_count, zero
   logic                 req_tuser;        // operation
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [23:0]          rsp_tdata;        // result_day, result_month, result_year, zero
   logic [STATUS_W-1:0]  rsp_tuser;        // status
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [YEAR_W-1:0]    csr_data;

   int error_count;
   int outstanding;

   // idle knobs, owned by the main sequence
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int rx_hold_requests = 0;

   // receiver hold bookkeeping, owned by the receiver process; idle_cycles is the watchdog's
   int rx_hold_served = 0;
   int rx_hold_left = 0;
   int idle_cycles = 0;

   int window_lo[7] = '{1902, 1, 2000, 9999, 2100, 1, 1583};
   int window_hi[7] = '{2037, 9999, 2003, 9999, 1900, 1, 2400};

   always #5 clock = ~clock;

   gregorian_date_add_sub_days dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   gdas_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   // Result side: honor a requested long hold-off first, else stall at the
   // configured rate. Change tready on the falling edge only.
   always @(negedge clock) begin
      if (rx_hold_served != rx_hold_requests) begin
         rx_hold_served = rx_hold_served + 1;
         rx_hold_left = RX_HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
         rx_hold_left = rx_hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Watchdog: count cycles with no transaction on any channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Offer one date request; return at the falling edge after acceptance with
   // tvalid still high, so back-to-back requests drop tvalid only for drawn idle gaps.
   task automatic send_date(input logic op, input logic [DAY_W-1:0] day,
                            input logic [MONTH_W-1:0] month, input int year,
                            input logic [COUNT_BITS-1:0] count);
      logic [YEAR_W-1:0] yr;
      yr = year[YEAR_W-1:0];
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, count, yr, month, day};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Hold the request side until every predicted result has come back.
   task automatic wait_results_drained();
      while (outstanding != 0) @(negedge clock);
   endtask

   // Write both year window registers; call only with the block idle.
   task automatic write_year_window(input int lo, input int hi);
      csr_valid <= 1'b1;
      csr_index <= CSR_YEAR_MIN;
      csr_data  <= lo[YEAR_W-1:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_index <= CSR_YEAR_MAX;
      csr_data  <= hi[YEAR_W-1:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly short walks; a few full-width counts keep the run time sane.
   function automatic logic [COUNT_BITS-1:0] draw_day_count();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 55) return COUNT_BITS'($urandom_range(400));
      else if (pick < 80) return COUNT_BITS'($urandom_range(4000));
      else if (pick < 92) return COUNT_BITS'($urandom);
      else if (pick < 96) return {COUNT_BITS{1'b1}};
      else return COUNT_BITS'($urandom_range(3));
   endfunction

   // Mostly well-formed dates inside the window, with month ends and window
   // edges favored; the rest is raw noise over the day and month fields and years up to 9999.
   task automatic send_random_date(input int lo, input int hi);
      logic             op;
      logic [DAY_W-1:0] day;
      logic [MONTH_W-1:0] month;
      int               year;
      op = 1'($urandom_range(1));
      if ($urandom_range(99) < 15) begin
         day   = DAY_W'($urandom_range(31));
         month = MONTH_W'($urandom_range(15));
         year  = int'($urandom_range(9999));
      end else begin
         month = MONTH_W'($urandom_range(12, 1));
         if ($urandom_range(99) < 70) day = DAY_W'($urandom_range(28, 1));
         else day = DAY_W'($urandom_range(31, 28));
         if (lo > hi) year = int'($urandom_range(9999));
         else if ($urandom_range(99) < 25) year = $urandom_range(1) ? lo : hi;
         else year = int'($urandom_range(hi, lo));
      end
      send_date(op, day, month, year, draw_day_count());
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_ADD;
      csr_valid  = 1'b0;
      csr_index  = CSR_YEAR_MIN;
      csr_data   = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, reset window 1902..2037.
      tx_idle_pct = 20;
      rx_idle_pct = 20;
      send_date(OP_ADD, 5'd1,  4'd1,  1902, 16'd0);        // zero count
      send_date(OP_ADD, 5'd31, 4'd12, 2036, 16'd1);        // year rollover
      send_date(OP_ADD, 5'd31, 4'd12, 2037, 16'd1);        // past the top year
      send_date(OP_SUB, 5'd1,  4'd1,  1902, 16'd1);        // below the bottom year
      send_date(OP_SUB, 5'd1,  4'd3,  1904, 16'd1);        // leap February
      send_date(OP_SUB, 5'd1,  4'd3,  1903, 16'd1);        // common February
      send_date(OP_ADD, 5'd29, 4'd2,  1904, 16'd365);
      send_date(OP_ADD, 5'd29, 4'd2,  1903, 16'd1);        // no Feb 29 that year
      send_date(OP_ADD, 5'd0,  4'd6,  2000, 16'd5);        // zero day
      send_date(OP_ADD, 5'd15, 4'd0,  2000, 16'd5);        // zero month
      send_date(OP_SUB, 5'd15, 4'd13, 2000, 16'd5);        // month above December
      send_date(OP_SUB, 5'd31, 4'd15, 2000, 16'd5);
      send_date(OP_ADD, 5'd31, 4'd4,  2000, 16'd5);        // day past month end
      send_date(OP_ADD, 5'd10, 4'd10, 0,    16'd5);        // zero year
      send_date(OP_ADD, 5'd10, 4'd10, 9999, 16'd5);        // year above window
      send_date(OP_ADD, 5'd1,  4'd1,  1902, 16'hFFFF);
      send_date(OP_SUB, 5'd31, 4'd12, 2037, 16'hFFFF);
      send_date(OP_SUB, 5'd15, 4'd7,  1970, 16'hFFFF);
      req_tvalid <= 1'b0;
      wait_results_drained();

      // Directed, full window: century leap rules and full-width walks.
      write_year_window(1, 9999);
      send_date(OP_ADD, 5'd28, 4'd2,  1900, 16'd1);        // century, not leap
      send_date(OP_ADD, 5'd28, 4'd2,  2000, 16'd1);        // divisible by 400
      send_date(OP_SUB, 5'd1,  4'd3,  2100, 16'd1);
      send_date(OP_ADD, 5'd1,  4'd1,  1,    16'hFFFF);
      send_date(OP_SUB, 5'd31, 4'd12, 9999, 16'hFFFF);
      send_date(OP_ADD, 5'd31, 4'd12, 9999, 16'd1);        // past year 9999
      send_date(OP_SUB, 5'd1,  4'd1,  1,    16'd1);        // before year 1
      req_tvalid <= 1'b0;
      wait_results_drained();

      // Random sets, one year window each; idle pattern moves from sender-light
      // to receiver-light to none.
      for (int w = 0; w < 7; w++) begin
         write_year_window(window_lo[w], window_hi[w]);
         if (w < 3) begin
            tx_idle_pct = 36;
            rx_idle_pct = 79;
         end else if (w < 5) begin
            tx_idle_pct = 79;
            rx_idle_pct = 36;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         // stall results for a long stretch so the input side backs up
         if (w == 6) rx_hold_requests = rx_hold_requests + 1;
         for (int i = 0; i < ITEMS_PER_SET; i++) send_random_date(window_lo[w], window_hi[w]);
         req_tvalid <= 1'b0;
         wait_results_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
